FILE: hw/rtl/rrp_pkg.sv
`default_nettype none

package rrp_pkg;

  localparam int ANGLE_BITS = 9;
  localparam int FULL_TURN = 360;
  localparam int SIN_ENTRIES = 91;
  localparam real PI = 3.14159265358979323846;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_PIVOT_X = 2'd0,
    CFG_PIVOT_Y = 2'd1,
    CFG_ANGLE   = 2'd2
  } cfg_idx_t;

  // per-corner control travelling alongside the coordinates
  typedef struct packed {
    logic [1:0] index;
    logic       last;
  } corner_ctl_t;

  // sin(k degrees) scaled by 2^frac_bits, rounded to nearest
  function automatic longint sin_q(input int k, input int frac_bits);
    real r;
    r = $sin(real'(k) * PI / 180.0);
    return longint'($floor(r * (2.0 ** frac_bits) + 0.5));
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rrp_trig.sv
`default_nettype none

module rrp_trig #(
  parameter int TRIG_FRAC_BITS = 14,
  localparam int TW = TRIG_FRAC_BITS + 2
) (
  input  wire logic                              clk,
  input  wire logic [rrp_pkg::ANGLE_BITS-1:0]    angle_degrees,
  output logic signed [TW-1:0]                   sin_q,
  output logic signed [TW-1:0]                   cos_q
);
  import rrp_pkg::*;

  logic signed [TW-1:0] tab [SIN_ENTRIES];

  for (genvar k = 0; k < SIN_ENTRIES; k++) begin : g_tab
    localparam logic signed [TW-1:0] V = TW'(rrp_pkg::sin_q(k, TRIG_FRAC_BITS));
    assign tab[k] = V;
  end

  logic [ANGLE_BITS-1:0] a;
  logic [6:0]            s_idx;
  logic [6:0]            c_idx;
  logic                  s_neg;
  logic                  c_neg;
  logic signed [TW-1:0]  s_mag;
  logic signed [TW-1:0]  c_mag;

  always_comb begin
    // wrap 360..511 back into one turn
    a = (angle_degrees >= ANGLE_BITS'(FULL_TURN))
        ? angle_degrees - ANGLE_BITS'(FULL_TURN) : angle_degrees;
    if (a <= ANGLE_BITS'(90)) begin
      s_idx = 7'(a);
      c_idx = 7'(ANGLE_BITS'(90) - a);
      s_neg = 1'b0;
      c_neg = 1'b0;
    end else if (a <= ANGLE_BITS'(180)) begin
      s_idx = 7'(ANGLE_BITS'(180) - a);
      c_idx = 7'(a - ANGLE_BITS'(90));
      s_neg = 1'b0;
      c_neg = 1'b1;
    end else if (a <= ANGLE_BITS'(270)) begin
      s_idx = 7'(a - ANGLE_BITS'(180));
      c_idx = 7'(ANGLE_BITS'(270) - a);
      s_neg = 1'b1;
      c_neg = 1'b1;
    end else begin
      s_idx = 7'(ANGLE_BITS'(360) - a);
      c_idx = 7'(a - ANGLE_BITS'(270));
      s_neg = 1'b1;
      c_neg = 1'b0;
    end
    s_mag = tab[s_idx];
    c_mag = tab[c_idx];
  end

  // the angle must change only while idle, which the block does not enforce; then the registered copy is current
  always_ff @(posedge clk) begin
    sin_q <= s_neg ? -s_mag : s_mag;
    cos_q <= c_neg ? -c_mag : c_mag;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rrp_corner.sv
`default_nettype none

module rrp_corner #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_BITS-1:0]  left_x,
  input  wire logic signed [COORD_BITS-1:0]  top_y,
  input  wire logic signed [COORD_BITS-1:0]  right_x,
  input  wire logic signed [COORD_BITS-1:0]  bottom_y,
  output logic                               c_valid,
  input  wire logic                          c_ready,
  output logic signed [COORD_BITS-1:0]       c_x,
  output logic signed [COORD_BITS-1:0]       c_y,
  output rrp_pkg::corner_ctl_t               c_ctl
);
  import rrp_pkg::*;

  logic                         held;
  logic [1:0]                   cnt;
  logic signed [COORD_BITS-1:0] lx;
  logic signed [COORD_BITS-1:0] ty;
  logic signed [COORD_BITS-1:0] rx;
  logic signed [COORD_BITS-1:0] by;
  logic                         advance;
  logic                         take;

  assign advance  = held && c_ready;
  // free the slot on the transfer of the fourth corner
  assign in_stall = held && !(c_ready && (cnt == 2'd3));
  assign take     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (take) begin
        held <= 1'b1;
      end else if (advance && (cnt == 2'd3)) begin
        held <= 1'b0;
      end
      if (advance) begin
        cnt <= cnt + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      lx <= left_x;
      ty <= top_y;
      rx <= right_x;
      by <= bottom_y;
    end
  end

  always_comb begin
    c_valid    = held;
    c_x        = ((cnt == 2'd1) || (cnt == 2'd2)) ? rx : lx;
    c_y        = cnt[1] ? by : ty;
    c_ctl.index = cnt;
    c_ctl.last  = (cnt == 2'd3);
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rrp_rotate.sv
`default_nettype none

module rrp_rotate #(
  parameter int COORD_BITS = 16,
  parameter int TRIG_FRAC_BITS = 14,
  localparam int TW = TRIG_FRAC_BITS + 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          c_valid,
  output logic                               c_ready,
  input  wire logic signed [COORD_BITS-1:0]  c_x,
  input  wire logic signed [COORD_BITS-1:0]  c_y,
  input  wire rrp_pkg::corner_ctl_t          c_ctl,
  input  wire logic signed [COORD_BITS-1:0]  pivot_x,
  input  wire logic signed [COORD_BITS-1:0]  pivot_y,
  input  wire logic signed [TW-1:0]          sin_q,
  input  wire logic signed [TW-1:0]          cos_q,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_BITS-1:0]       corner_x,
  output logic signed [COORD_BITS-1:0]       corner_y,
  output logic [1:0]                         corner_index,
  output logic                               last_corner
);
  import rrp_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = DW + TW;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] RND = {{(SW - TRIG_FRAC_BITS){1'b0}},
                                          {TRIG_FRAC_BITS{1'b1}}};

  logic                 p_valid;
  corner_ctl_t          p_ctl;
  logic signed [PW-1:0] xc;
  logic signed [PW-1:0] ys;
  logic signed [PW-1:0] yc;
  logic signed [PW-1:0] xs;
  logic                 o_ready;

  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;

  assign o_ready = !out_valid || !out_stall;
  assign c_ready = !p_valid || o_ready;

  assign dx = DW'(c_x) - DW'(pivot_x);
  assign dy = DW'(c_y) - DW'(pivot_y);

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (c_ready) begin
      p_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      p_ctl <= c_ctl;
      xc    <= PW'(dx) * PW'(cos_q);
      ys    <= PW'(dy) * PW'(sin_q);
      yc    <= PW'(dy) * PW'(cos_q);
      xs    <= PW'(dx) * PW'(sin_q);
    end
  end

  logic signed [SW-1:0] sx;
  logic signed [SW-1:0] sy;
  logic signed [SW-1:0] qx;
  logic signed [SW-1:0] qy;
  logic signed [SW-1:0] rx;
  logic signed [SW-1:0] ry;
  logic signed [COORD_BITS-1:0] sat_x;
  logic signed [COORD_BITS-1:0] sat_y;

  always_comb begin
    sx = SW'(xc) + SW'(ys);
    sy = SW'(yc) - SW'(xs);
    // the shift alone rounds down: bias negative values before the shift so the result rounds toward zero
    qx = (sx[SW-1] ? (sx + RND) : sx) >>> TRIG_FRAC_BITS;
    qy = (sy[SW-1] ? (sy + RND) : sy) >>> TRIG_FRAC_BITS;
    rx = qx + SW'(pivot_x);
    ry = qy + SW'(pivot_y);
    if ((&rx[SW-1:COORD_BITS-1]) || !(|rx[SW-1:COORD_BITS-1])) begin
      sat_x = rx[COORD_BITS-1:0];
    end else begin
      sat_x = {rx[SW-1], {(COORD_BITS-1){!rx[SW-1]}}};
    end
    if ((&ry[SW-1:COORD_BITS-1]) || !(|ry[SW-1:COORD_BITS-1])) begin
      sat_y = ry[COORD_BITS-1:0];
    end else begin
      sat_y = {ry[SW-1], {(COORD_BITS-1){!ry[SW-1]}}};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready) begin
      corner_x     <= sat_x;
      corner_y     <= sat_y;
      corner_index <= p_ctl.index;
      last_corner  <= p_ctl.last;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/rectangle_rotate_about_pivot.sv
`default_nettype none

// Rotates the four corners of an axis-aligned rectangle about a pivot.
// Input channel (in_valid/in_stall) carries one rectangle as left_x, top_y,
// right_x, bottom_y. Output channel (out_valid/out_stall) carries one corner
// per transfer, in order top-left, top-right, bottom-right, bottom-left;
// last_corner marks the fourth.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes pivot_x,
// pivot_y and angle_degrees; write it only while no rectangle is in flight.
// The angle is applied negated; 360..511 wrap.
// The first corner passes through the input holding register, the product
// stage and the result register; the rest follow one per cycle while the
// output does not stall. A rectangle is held until its four corners have
// gone; the next rectangle is taken on the cycle its predecessor's fourth
// corner leaves the input register, so there is no gap between rectangles.
// A stall on the output holds the result register and backs up the two
// internal stages; the input stalls once its holding register cannot drain.
// Reset clears all valid flags, the corner counter and the configuration
// registers to zero.
module rectangle_rotate_about_pivot #(
  parameter int COORD_BITS = 16,
  parameter int TRIG_FRAC_BITS = 14,
  localparam int CFG_W = (COORD_BITS > rrp_pkg::ANGLE_BITS) ? COORD_BITS
                                                            : rrp_pkg::ANGLE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [COORD_BITS-1:0]  left_x,
  input  wire logic signed [COORD_BITS-1:0]  top_y,
  input  wire logic signed [COORD_BITS-1:0]  right_x,
  input  wire logic signed [COORD_BITS-1:0]  bottom_y,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [COORD_BITS-1:0]       corner_x,
  output logic signed [COORD_BITS-1:0]       corner_y,
  output logic [1:0]                         corner_index,
  output logic                               last_corner,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [CFG_W-1:0]              cfg_data
);
  import rrp_pkg::*;

  localparam int TW = TRIG_FRAC_BITS + 2;

  logic signed [COORD_BITS-1:0] pivot_x;
  logic signed [COORD_BITS-1:0] pivot_y;
  logic [ANGLE_BITS-1:0]        angle_degrees;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_x       <= '0;
      pivot_y       <= '0;
      angle_degrees <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PIVOT_X: pivot_x       <= cfg_data[COORD_BITS-1:0];
        CFG_PIVOT_Y: pivot_y       <= cfg_data[COORD_BITS-1:0];
        CFG_ANGLE:   angle_degrees <= cfg_data[ANGLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic signed [TW-1:0] sin_q;
  logic signed [TW-1:0] cos_q;

  rrp_trig #(
    .TRIG_FRAC_BITS(TRIG_FRAC_BITS)
  ) u_trig (
    .clk           (clk),
    .angle_degrees (angle_degrees),
    .sin_q         (sin_q),
    .cos_q         (cos_q)
  );

  logic                         c_valid;
  logic                         c_ready;
  logic signed [COORD_BITS-1:0] c_x;
  logic signed [COORD_BITS-1:0] c_y;
  corner_ctl_t                  c_ctl;

  rrp_corner #(
    .COORD_BITS(COORD_BITS)
  ) u_corner (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .left_x   (left_x),
    .top_y    (top_y),
    .right_x  (right_x),
    .bottom_y (bottom_y),
    .c_valid  (c_valid),
    .c_ready  (c_ready),
    .c_x      (c_x),
    .c_y      (c_y),
    .c_ctl    (c_ctl)
  );

  rrp_rotate #(
    .COORD_BITS     (COORD_BITS),
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_rotate (
    .clk          (clk),
    .rst          (rst),
    .c_valid      (c_valid),
    .c_ready      (c_ready),
    .c_x          (c_x),
    .c_y          (c_y),
    .c_ctl        (c_ctl),
    .pivot_x      (pivot_x),
    .pivot_y      (pivot_y),
    .sin_q        (sin_q),
    .cos_q        (cos_q),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .corner_x     (corner_x),
    .corner_y     (corner_y),
    .corner_index (corner_index),
    .last_corner  (last_corner)
  );

endmodule

`default_nettype wire
